### rtl/ssa_pkg.sv
package ssa_pkg;

   localparam int SAMPLE_BITS       = 16;
   localparam int COUNT_BITS        = 24;
   localparam int BAD_SLOTS_DEFAULT = 4;

   localparam int COUNT_W = COUNT_BITS + 1;
   localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS + 1;
   localparam int MAG_W   = SUM_W - 1;
   localparam int SQ_W    = 2 * SAMPLE_BITS;
   localparam int SUMSQ_W = 2 * SAMPLE_BITS - 2 + COUNT_BITS + 1;
   localparam int PROD_W  = COUNT_W + SUMSQ_W;
   localparam int DVD_W   = PROD_W + 16;
   localparam int DVR_W   = 2 * COUNT_W;
   localparam int QUO_W   = 64;
   localparam int Q8_W    = 24;
   localparam int ITER_W  = $clog2(DVD_W);
   localparam int SQRT_STEPS = QUO_W / 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;
   localparam int BADCNT_W   = 3;

   localparam logic [REG_IDX_W-1:0] REG_BAD_COUNT = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BAD_A     = 3'd1;

   // result word layout, lowest field first
   localparam int RSP_COUNT_LSB = 0;
   localparam int RSP_MIN_LSB   = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_MAX_LSB   = RSP_MIN_LSB + SAMPLE_BITS;
   localparam int RSP_MEAN_LSB  = RSP_MAX_LSB + SAMPLE_BITS;
   localparam int RSP_SD_LSB    = RSP_MEAN_LSB + Q8_W;
   localparam int RSP_OVF_LSB   = RSP_SD_LSB + Q8_W;
   localparam int RSP_USED_W    = RSP_OVF_LSB + 1;
   localparam int RSP_W         = ((RSP_USED_W + 7) / 8) * 8;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [SQ_W-1:0]               square;
      logic                          bad;
      logic                          final_item;
   } q_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]            count;
      logic signed [SAMPLE_BITS-1:0] min;
      logic signed [SAMPLE_BITS-1:0] max;
      logic signed [SUM_W-1:0]       sum;
      logic [SUMSQ_W-1:0]            sumsq;
      logic                          ovf;
   } snap_type;

   typedef enum logic [2:0] {
      FIN_IDLE,
      FIN_MEAN,
      FIN_MULA,
      FIN_MULB,
      FIN_DIFF,
      FIN_STD,
      FIN_SQRT,
      FIN_DONE
   } fin_state_type;

endpackage

### rtl/ssa_front.sv
module ssa_front #(
   parameter int BAD_SLOTS = ssa_pkg::BAD_SLOTS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [ssa_pkg::SAMPLE_BITS-1:0] sample,
   input  logic                                  final_item,
   output ssa_pkg::q_item_type                   item,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ssa_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [ssa_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [ssa_pkg::CSR_DATA_W-1:0]        csr_prdata
);

   logic [ssa_pkg::BADCNT_W-1:0]         bad_count_ff, bad_count_in;
   logic signed [ssa_pkg::SAMPLE_BITS-1:0] bad_val_ff [BAD_SLOTS];
   logic signed [ssa_pkg::SAMPLE_BITS-1:0] bad_val_in [BAD_SLOTS];
   logic [ssa_pkg::REG_IDX_W-1:0]        idx;
   logic                                 wr;
   logic [ssa_pkg::BADCNT_W-1:0]         slots;
   logic signed [ssa_pkg::SQ_W-1:0]      sq;
   logic                                 hit;

   assign idx = csr_paddr[ssa_pkg::CSR_ADDR_W-1:2];
   assign wr  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      bad_count_in = bad_count_ff;
      for (int i = 0; i < BAD_SLOTS; i++) begin
         bad_val_in[i] = bad_val_ff[i];
      end
      if (wr) begin
         if (idx == ssa_pkg::REG_BAD_COUNT) begin
            bad_count_in = csr_pwdata[ssa_pkg::BADCNT_W-1:0];
         end
         for (int i = 0; i < BAD_SLOTS; i++) begin
            if (idx == ssa_pkg::REG_BAD_A + ssa_pkg::REG_IDX_W'(i)) begin
               bad_val_in[i] = csr_pwdata[ssa_pkg::SAMPLE_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_count_ff <= '0;
         for (int i = 0; i < BAD_SLOTS; i++) begin
            bad_val_ff[i] <= '0;
         end
      end else begin
         bad_count_ff <= bad_count_in;
         for (int i = 0; i < BAD_SLOTS; i++) begin
            bad_val_ff[i] <= bad_val_in[i];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (idx == ssa_pkg::REG_BAD_COUNT) begin
         csr_prdata = ssa_pkg::CSR_DATA_W'(bad_count_ff);
      end
      for (int i = 0; i < BAD_SLOTS; i++) begin
         if (idx == ssa_pkg::REG_BAD_A + ssa_pkg::REG_IDX_W'(i)) begin
            csr_prdata = ssa_pkg::CSR_DATA_W'(unsigned'(bad_val_ff[i]));
         end
      end
   end

   // count above the slot number saturates
   assign slots = (bad_count_ff > ssa_pkg::BADCNT_W'(BAD_SLOTS)) ?
                  ssa_pkg::BADCNT_W'(BAD_SLOTS) : bad_count_ff;

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < BAD_SLOTS; i++) begin
         if ((ssa_pkg::BADCNT_W'(i) < slots) && (sample == bad_val_ff[i])) begin
            hit = 1'b1;
         end
      end
   end

   assign sq = sample * sample;

   always_comb begin
      item.sample     = sample;
      item.square     = unsigned'(sq);
      item.bad        = hit;
      item.final_item = final_item;
   end

endmodule

### rtl/ssa_queue.sv
module ssa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ssa_pkg::q_item_type in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output ssa_pkg::q_item_type out_item
);

   ssa_pkg::q_item_type             ent_ff [ssa_pkg::QUEUE_DEPTH];
   logic [ssa_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ssa_pkg::QPTR_W:0]        fill_ff, fill_in;
   logic                            push, pop;

   assign in_ready  = (fill_ff != (ssa_pkg::QPTR_W+1)'(ssa_pkg::QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_item  = ent_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

### rtl/ssa_accum.sv
module ssa_accum (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  ssa_pkg::q_item_type q_item,
   output logic                start,
   output ssa_pkg::snap_type   snap,
   input  logic                fin_ready
);

   ssa_pkg::snap_type run_ff, run_in, upd;
   logic              take, first;

   // a final item waits until the finishing unit is free
   assign q_ready = !q_item.final_item || fin_ready;
   assign take    = q_valid & q_ready;
   assign first   = (run_ff.count == '0);

   always_comb begin
      upd = run_ff;
      if (!q_item.bad) begin
         if (run_ff.count[ssa_pkg::COUNT_BITS]) begin
            upd.ovf = 1'b1;
         end else begin
            if (first || q_item.sample < run_ff.min) upd.min = q_item.sample;
            if (first || q_item.sample > run_ff.max) upd.max = q_item.sample;
            upd.sum   = run_ff.sum + {{(ssa_pkg::SUM_W-ssa_pkg::SAMPLE_BITS)
                                       {q_item.sample[ssa_pkg::SAMPLE_BITS-1]}},
                                      q_item.sample};
            upd.sumsq = run_ff.sumsq + ssa_pkg::SUMSQ_W'(q_item.square);
            upd.count = run_ff.count + 1'b1;
         end
      end
   end

   always_comb begin
      run_in = run_ff;
      if (take) begin
         run_in = q_item.final_item ? '0 : upd;
      end
   end

   assign start = take & q_item.final_item;
   assign snap  = upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

endmodule

### rtl/ssa_finish.sv
module ssa_finish (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  ssa_pkg::snap_type           snap,
   output logic                        fin_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ssa_pkg::RSP_W-1:0]   rsp_data
);

   localparam int MAG_W  = ssa_pkg::MAG_W;
   localparam int PROD_W = ssa_pkg::PROD_W;
   localparam int DVD_W  = ssa_pkg::DVD_W;
   localparam int DVR_W  = ssa_pkg::DVR_W;
   localparam int QUO_W  = ssa_pkg::QUO_W;
   localparam int Q8_W   = ssa_pkg::Q8_W;
   localparam int IT_W   = ssa_pkg::ITER_W;

   ssa_pkg::fin_state_type st_ff, st_in;
   logic [IT_W-1:0]         it_ff, it_in;
   ssa_pkg::snap_type       snap_ff, snap_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [DVR_W-1:0]        nn1_ff, nn1_in;
   logic [PROD_W-1:0]       acc_ff, acc_in, a_ff, a_in;
   logic [ssa_pkg::SUMSQ_W-1:0] mcand_ff, mcand_in;
   logic [MAG_W-1:0]        mplier_ff, mplier_in;
   logic [DVR_W-1:0]        rem_ff, rem_in, dvr_ff, dvr_in;
   logic [DVD_W-1:0]        dvd_ff, dvd_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [Q8_W-1:0]         mean_ff, mean_in, sd_ff, sd_in;
   logic [QUO_W-1:0]        sx_ff, sx_in, sr_ff, sr_in, sb_ff, sb_in;

   logic [DVR_W:0]          r2;
   logic                    dge;
   logic [DVR_W-1:0]        div_rem;
   logic [QUO_W-1:0]        div_quo;
   logic [PROD_W-1:0]       mul_acc;
   logic [QUO_W-1:0]        sq_t;
   logic                    sge;
   logic [QUO_W-1:0]        sq_x, sq_r;
   logic [ssa_pkg::SUM_W-1:0] sum_abs;
   logic [PROD_W-1:0]       diff;
   logic                    last_it;

   // shared step units
   assign r2      = {rem_ff, dvd_ff[DVD_W-1]};
   assign dge     = (r2 >= {1'b0, dvr_ff});
   assign div_rem = dge ? DVR_W'(r2 - {1'b0, dvr_ff}) : DVR_W'(r2);
   assign div_quo = {quo_ff[QUO_W-2:0], dge};
   assign mul_acc = {acc_ff[PROD_W-2:0], 1'b0} +
                    (mplier_ff[MAG_W-1] ? PROD_W'(mcand_ff) : '0);
   assign sq_t    = sr_ff + sb_ff;
   assign sge     = (sx_ff >= sq_t);
   assign sq_x    = sge ? sx_ff - sq_t : sx_ff;
   assign sq_r    = sge ? (sr_ff >> 1) + sb_ff : (sr_ff >> 1);
   assign sum_abs = snap.sum[ssa_pkg::SUM_W-1] ? -snap.sum : snap.sum;
   assign diff    = (a_ff >= acc_ff) ? a_ff - acc_ff : acc_ff - a_ff;

   always_comb begin
      last_it = 1'b0;
      unique case (st_ff)
         ssa_pkg::FIN_MEAN,
         ssa_pkg::FIN_STD:  last_it = (it_ff == IT_W'(DVD_W - 1));
         ssa_pkg::FIN_MULA: last_it = (it_ff == IT_W'(ssa_pkg::COUNT_W - 1));
         ssa_pkg::FIN_MULB: last_it = (it_ff == IT_W'(MAG_W - 1));
         ssa_pkg::FIN_SQRT: last_it = (it_ff == IT_W'(ssa_pkg::SQRT_STEPS - 1));
         default:           last_it = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ssa_pkg::FIN_IDLE: if (start) st_in = ssa_pkg::FIN_MEAN;
         ssa_pkg::FIN_MEAN: if (last_it) st_in = ssa_pkg::FIN_MULA;
         ssa_pkg::FIN_MULA: if (last_it) st_in = ssa_pkg::FIN_MULB;
         ssa_pkg::FIN_MULB: if (last_it) st_in = ssa_pkg::FIN_DIFF;
         ssa_pkg::FIN_DIFF: st_in = ssa_pkg::FIN_STD;
         ssa_pkg::FIN_STD:  if (last_it) st_in = ssa_pkg::FIN_SQRT;
         ssa_pkg::FIN_SQRT: if (last_it) st_in = ssa_pkg::FIN_DONE;
         ssa_pkg::FIN_DONE: if (rsp_ready) st_in = ssa_pkg::FIN_IDLE;
         default:           st_in = ssa_pkg::FIN_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      fin_ready = (st_ff == ssa_pkg::FIN_IDLE);
      rsp_valid = (st_ff == ssa_pkg::FIN_DONE);
   end

   // datapath
   always_comb begin
      it_in     = it_ff + 1'b1;
      snap_in   = snap_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      nn1_in    = DVR_W'(snap_ff.count * (snap_ff.count - 1'b1));
      acc_in    = acc_ff;
      a_in      = a_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      dvr_in    = dvr_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      mean_in   = mean_ff;
      sd_in     = sd_ff;
      sx_in     = sx_ff;
      sr_in     = sr_ff;
      sb_in     = sb_ff;
      if (last_it) it_in = '0;
      unique case (st_ff)
         ssa_pkg::FIN_IDLE: begin
            it_in   = '0;
            snap_in = snap;
            mag_in  = MAG_W'(sum_abs);
            neg_in  = snap.sum[ssa_pkg::SUM_W-1];
            // mean: (|sum| << 8) / n
            dvd_in  = DVD_W'({MAG_W'(sum_abs), 8'h00});
            dvr_in  = DVR_W'(snap.count);
            rem_in  = '0;
            quo_in  = '0;
         end
         ssa_pkg::FIN_MEAN: begin
            rem_in = div_rem;
            quo_in = div_quo;
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
            if (last_it) begin
               mean_in   = neg_ff ? -div_quo[Q8_W-1:0] : div_quo[Q8_W-1:0];
               acc_in    = '0;
               mcand_in  = snap_ff.sumsq;
               mplier_in = {snap_ff.count, (MAG_W - ssa_pkg::COUNT_W)'(0)};
            end
         end
         ssa_pkg::FIN_MULA: begin
            acc_in    = mul_acc;
            mplier_in = {mplier_ff[MAG_W-2:0], 1'b0};
            if (last_it) begin
               a_in      = mul_acc;
               acc_in    = '0;
               mcand_in  = ssa_pkg::SUMSQ_W'(mag_ff);
               mplier_in = mag_ff;
            end
         end
         ssa_pkg::FIN_MULB: begin
            acc_in    = mul_acc;
            mplier_in = {mplier_ff[MAG_W-2:0], 1'b0};
         end
         ssa_pkg::FIN_DIFF: begin
            it_in  = '0;
            dvd_in = {diff, 16'h0000};
            dvr_in = nn1_ff;
            rem_in = '0;
            quo_in = '0;
         end
         ssa_pkg::FIN_STD: begin
            rem_in = div_rem;
            quo_in = div_quo;
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
            if (last_it) begin
               sx_in = div_quo;
               sr_in = '0;
               sb_in = QUO_W'(1) << (QUO_W - 2);
            end
         end
         ssa_pkg::FIN_SQRT: begin
            sx_in = sq_x;
            sr_in = sq_r;
            sb_in = sb_ff >> 2;
            if (last_it) begin
               sd_in = (sq_r > QUO_W'({Q8_W{1'b1}})) ? {Q8_W{1'b1}} : sq_r[Q8_W-1:0];
            end
         end
         ssa_pkg::FIN_DONE: it_in = '0;
         default:           it_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ssa_pkg::FIN_IDLE;
         it_ff <= '0;
      end else begin
         st_ff <= st_in;
         it_ff <= it_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff   <= snap_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      nn1_ff    <= nn1_in;
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      dvr_ff    <= dvr_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      mean_ff   <= mean_in;
      sd_ff     <= sd_in;
      sx_ff     <= sx_in;
      sr_ff     <= sr_in;
      sb_ff     <= sb_in;
   end

   always_comb begin
      logic none, few;
      none = (snap_ff.count == '0);
      few  = (snap_ff.count < ssa_pkg::COUNT_W'(2));
      rsp_data = '0;
      rsp_data[ssa_pkg::RSP_COUNT_LSB +: ssa_pkg::COUNT_W] = snap_ff.count;
      rsp_data[ssa_pkg::RSP_MIN_LSB +: ssa_pkg::SAMPLE_BITS] = none ? '0 : snap_ff.min;
      rsp_data[ssa_pkg::RSP_MAX_LSB +: ssa_pkg::SAMPLE_BITS] = none ? '0 : snap_ff.max;
      rsp_data[ssa_pkg::RSP_MEAN_LSB +: Q8_W] = none ? '0 : mean_ff;
      rsp_data[ssa_pkg::RSP_SD_LSB +: Q8_W]   = few ? '0 : sd_ff;
      rsp_data[ssa_pkg::RSP_OVF_LSB]          = snap_ff.ovf;
   end

endmodule

### rtl/sample_statistics_accumulator.sv
// Samples enter one per cycle while the queue has room; a non-last item gives no result.
// A last item passes through the queue, then the finisher computes its result with
// a bit-serial divider (96 steps, run twice), a shift-add multiplier (25 + 40 steps),
// one difference step and a 32-step square root.
// A later last item waits in the queue until the previous result has been taken.
// Synchronous active-high reset clears bad-value registers, totals, queue and finisher.
module sample_statistics_accumulator #(
   parameter int BAD_SLOTS = ssa_pkg::BAD_SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample input channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ssa_pkg::SAMPLE_BITS-1:0]     req_tdata,  // [15:0] sample
   input  logic                                req_tlast,  // final_item
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [24:0] kept_count, [40:25] minimum, [56:41] maximum, [80:57] mean_q8,
   // [104:81] std_dev_q8, [105] overflowed, [111:106] zero
   output logic [ssa_pkg::RSP_W-1:0]           rsp_tdata,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ssa_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ssa_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ssa_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   ssa_pkg::q_item_type front_item, head_item;
   ssa_pkg::snap_type   snap;
   logic                head_valid, head_ready;
   logic                start, fin_ready;

   assign csr_pready = 1'b1;

   // front: register file, bad-value match, sample square
   ssa_front #(.BAD_SLOTS(BAD_SLOTS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .sample      (signed'(req_tdata)),
      .final_item  (req_tlast),
      .item        (front_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

   // short queue decouples intake from the back end
   ssa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (front_item),
      .out_valid (head_valid),
      .out_ready (head_ready),
      .out_item  (head_item)
   );

   // running min / max / sum / sum of squares / count
   ssa_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (head_valid),
      .q_ready   (head_ready),
      .q_item    (head_item),
      .start     (start),
      .snap      (snap),
      .fin_ready (fin_ready)
   );

   // mean and deviation, holds the result until taken
   ssa_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .snap      (snap),
      .fin_ready (fin_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule

### rtl/ssa_checker.sv
module ssa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [ssa_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                       csr_pready
);

   localparam int CW = ssa_pkg::COUNT_W;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

   a_sd_few: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[CW-1:0] < CW'(2)) |->
         (rsp_tdata[ssa_pkg::RSP_SD_LSB +: ssa_pkg::Q8_W] == '0))
      else $error("deviation nonzero with under two samples");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[CW-1:0] == '0) |->
         (rsp_tdata[ssa_pkg::RSP_SD_LSB-1:ssa_pkg::RSP_MIN_LSB] == '0))
      else $error("min, max or mean nonzero with no samples");

endmodule

bind sample_statistics_accumulator ssa_checker u_ssa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

### tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS = ssa_pkg::SAMPLE_BITS;
   localparam int COUNT_BITS  = ssa_pkg::COUNT_BITS;
   localparam int COUNT_W     = ssa_pkg::COUNT_W;
   localparam int Q8_W        = ssa_pkg::Q8_W;
   localparam int RSP_W       = ssa_pkg::RSP_W;
   localparam int CSR_ADDR_W  = ssa_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W  = ssa_pkg::CSR_DATA_W;

   localparam int DRAIN_CYCLES = 400;   // time for the final divide and square root

   typedef struct {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   last;
   } sample_item_type;

   typedef struct {
      logic [COUNT_W-1:0]     count;
      logic [SAMPLE_BITS-1:0] min;
      logic [SAMPLE_BITS-1:0] max;
      logic [Q8_W-1:0]        mean;
      logic [Q8_W-1:0]        sd;
      logic                   ovf;
   } stats_type;

   // register indexes
   typedef enum int {
      IDX_BAD_COUNT = 0,
      IDX_BAD_A     = 1,
      IDX_BAD_B     = 2,
      IDX_BAD_C     = 3,
      IDX_BAD_D     = 4,
      IDX_PAST_END  = 5
   } reg_index_type;

   // idle modes
   typedef enum int {
      IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH
   } idle_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_BITS-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   sample_statistics_accumulator DUT (.*);

   always #1 clock = ~clock;

   // mirror of the configuration and running totals
   logic [2:0]             bad_count_m = '0;
   logic [SAMPLE_BITS-1:0] bad_m [4] = '{default: '0};
   longint                 acc_min, acc_max, acc_sum;
   longint unsigned        acc_sumsq, acc_count;
   bit                     acc_ovf;

   sample_item_type pending_samples[$];
   stats_type       expected_stats[$];
   idle_mode_type   idle_mode = IDLE_NONE;
   int              mismatches = 0;

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic bit is_bad_sample(logic signed [SAMPLE_BITS-1:0] s);
      int n;
      n = (bad_count_m > 4) ? 4 : bad_count_m;
      for (int i = 0; i < n; i++)
         if (bad_m[i] == s) return 1'b1;
      return 1'b0;
   endfunction

   // sender idles 68 in a hundred alone, 16 when both sides idle
   function automatic bit send_idle();
      int pct;
      pct = (idle_mode == IDLE_SEND) ? 68 : (idle_mode == IDLE_BOTH) ? 16 : 0;
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic bit recv_stall();
      int pct;
      pct = (idle_mode == IDLE_RECV) ? 68 : (idle_mode == IDLE_BOTH) ? 16 : 0;
      return $urandom_range(0, 99) < pct;
   endfunction

   // take one sample in; returns 1 and fills the statistics on a final item
   function automatic bit accumulate(sample_item_type it, output stats_type st);
      longint          s, mag_sum;
      longint unsigned m;
      logic [127:0]    a, b, d;
      longint unsigned q, sd;
      s = longint'($signed(it.sample));
      st = '{default: '0};
      if (!is_bad_sample(it.sample)) begin
         if (acc_count >= (64'd1 << COUNT_BITS)) begin
            acc_ovf = 1'b1;
         end else begin
            if (acc_count == 0) begin
               acc_min = s;
               acc_max = s;
            end else begin
               if (s < acc_min) acc_min = s;
               if (s > acc_max) acc_max = s;
            end
            acc_sum += s;
            acc_sumsq += longint'(s * s);
            acc_count++;
         end
      end
      if (!it.last) return 1'b0;
      mag_sum = acc_sum < 0 ? -acc_sum : acc_sum;
      st.count = COUNT_W'(acc_count);
      st.ovf = acc_ovf;
      if (acc_count > 0) begin
         m = (longint'(mag_sum) << 8) / acc_count;
         st.mean = Q8_W'(acc_sum < 0 ? -m : m);
         st.min = SAMPLE_BITS'(acc_min);
         st.max = SAMPLE_BITS'(acc_max);
      end
      if (acc_count > 1) begin
         a = 128'(acc_count) * 128'(acc_sumsq);
         b = 128'(mag_sum) * 128'(mag_sum);
         d = (a >= b) ? a - b : b - a;
         d = (d << 16) / (128'(acc_count) * 128'(acc_count - 1));
         q = d[63:0];
         sd = isqrt(q);
         st.sd = (sd > 64'hFFFFFF) ? 24'hFFFFFF : sd[23:0];
      end
      acc_min = 0; acc_max = 0; acc_sum = 0; acc_sumsq = 0; acc_count = 0; acc_ovf = 0;
      return 1'b1;
   endfunction

   // driver: next item when the channel is free
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_samples.size() != 0 && !send_idle()) begin
            req_tdata  <= pending_samples[0].sample;
            req_tlast  <= pending_samples[0].last;
            req_tvalid <= 1'b1;
            void'(pending_samples.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !recv_stall();
   end

   // monitor: predict on accepted samples, check accepted results
   always @(posedge clock) begin
      sample_item_type it;
      stats_type       st, got;
      if (!reset && req_tvalid && req_tready) begin
         it.sample = req_tdata;
         it.last   = req_tlast;
         if (accumulate(it, st)) expected_stats = {expected_stats, st};
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.count = rsp_tdata[ssa_pkg::RSP_COUNT_LSB +: COUNT_W];
         got.min   = rsp_tdata[ssa_pkg::RSP_MIN_LSB +: SAMPLE_BITS];
         got.max   = rsp_tdata[ssa_pkg::RSP_MAX_LSB +: SAMPLE_BITS];
         got.mean  = rsp_tdata[ssa_pkg::RSP_MEAN_LSB +: Q8_W];
         got.sd    = rsp_tdata[ssa_pkg::RSP_SD_LSB +: Q8_W];
         got.ovf   = rsp_tdata[ssa_pkg::RSP_OVF_LSB];
         if (expected_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %p", got);
         end else begin
            st = expected_stats.pop_front();
            if (got.count !== st.count || got.min !== st.min || got.max !== st.max ||
                got.mean !== st.mean || got.sd !== st.sd || got.ovf !== st.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, actual %p", st, got);
            end
         end
      end
   end

   task automatic write_reg(int idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == IDX_BAD_COUNT) bad_count_m = value[2:0];
      else if (idx <= IDX_BAD_D) bad_m[idx - 1] = value[SAMPLE_BITS-1:0];
   endtask

   // count plus four bad values; upper data bits are noise the block must drop
   task automatic configure(logic [2:0] cnt, logic [15:0] a, logic [15:0] b,
                            logic [15:0] c, logic [15:0] d);
      write_reg(IDX_BAD_COUNT, {$urandom} << 3 | cnt);
      write_reg(IDX_BAD_A, {$urandom} << 16 | a);
      write_reg(IDX_BAD_B, {$urandom} << 16 | b);
      write_reg(IDX_BAD_C, {$urandom} << 16 | c);
      write_reg(IDX_BAD_D, {$urandom} << 16 | d);
   endtask

   task automatic push_sample(logic [15:0] s, logic last);
      sample_item_type it;
      it.sample = s;
      it.last   = last;
      pending_samples = {pending_samples, it};
   endtask

   // random samples: bad-value hits, extremes, a narrow cluster, full range
   task automatic push_random(int count);
      int r;
      logic [15:0] s;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 20)      s = bad_m[$urandom_range(0, 3)];
         else if (r < 30) s = ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
         else if (r < 45) s = 16'($signed($urandom_range(0, 200)) - 100);
         else             s = 16'($urandom);
         push_sample(s, $urandom_range(0, 29) == 0);
      end
   endtask

   // all stimulus accepted and every result back, then let the finisher go quiet
   task automatic drain;
      wait (pending_samples.size() == 0 && !req_tvalid && expected_stats.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      acc_min = 0; acc_max = 0; acc_sum = 0; acc_sumsq = 0; acc_count = 0; acc_ovf = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      // phase 0: nothing excluded; lone sample, extremes pair, identical triple, mixed set
      idle_mode = IDLE_NONE;
      configure(3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      push_sample(16'h0005, 1'b1);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h8000, 1'b1);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h7FFF, 1'b1);
      push_sample(16'hFFFF, 1'b0);
      push_sample(16'h0000, 1'b0);
      push_sample(16'h0002, 1'b1);
      push_random(230);
      push_sample(16'h0000, 1'b1);
      drain();

      // phase 1: four slots holding the extremes and zero; empty sets
      idle_mode = IDLE_SEND;
      configure(3'd4, 16'h8000, 16'h7FFF, 16'h0000, 16'h1234);
      push_sample(16'h8000, 1'b1);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h0000, 1'b1);
      push_sample(16'h1234, 1'b0);
      push_sample(16'hFFF0, 1'b1);
      push_sample(16'h0007, 1'b0);
      push_sample(16'h0000, 1'b0);
      push_sample(16'hFFF9, 1'b1);
      push_random(230);
      push_sample(16'h1234, 1'b1);
      drain();

      // phase 2: count above the slot number saturates
      idle_mode = IDLE_RECV;
      configure(3'd7, 16'($urandom), 16'($urandom), 16'hFFFF, 16'h0001);
      push_random(240);
      push_sample(16'($urandom), 1'b1);
      drain();

      // phase 3: one slot only; the others must be ignored
      idle_mode = IDLE_BOTH;
      configure(3'd1, 16'h0000, 16'h8000, 16'h7FFF, 16'($urandom));
      write_reg(IDX_PAST_END, $urandom);   // index past the list, no effect
      push_random(240);
      push_sample(16'($urandom), 1'b1);
      drain();

      // phase 4: two slots, no idling
      idle_mode = IDLE_NONE;
      configure(3'd2, 16'($urandom), 16'h7FFF, 16'h8000, 16'h0000);
      push_random(240);
      push_sample(16'($urandom), 1'b1);
      drain();

      if (mismatches == 0 && expected_stats.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #4ms;
      $display("simulation failed");
      $finish;
   end

endmodule
